// ===== hw/rtl/tgr_pkg.sv =====
`timescale 1ns / 1ps
package tgr_pkg;

    typedef enum logic [1:0] {
        OP_DOWN   = 2'd0,
        OP_MOVE   = 2'd1,
        OP_UP     = 2'd2,
        OP_CANCEL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        EV_PAN_START  = 3'd0,
        EV_PAN_MOVE   = 3'd1,
        EV_LONG_PRESS = 3'd2,
        EV_PAN_END    = 3'd3,
        EV_TAP        = 3'd4,
        EV_RELEASE    = 3'd5
    } ev_t;

    localparam logic [0:0] REG_TAP_SLOP   = 1'b0;
    localparam logic [0:0] REG_LONG_PRESS = 1'b1;

    localparam logic [15:0] TAP_SLOP_RST   = 16'd128;
    localparam logic [31:0] LONG_PRESS_RST = 32'd500000;
    localparam logic [31:0] DT_FLOOR       = 32'd100;
    localparam logic signed [30:0] VEL_MAX = 31'sd655350000;

    // numerator width: 17 bit delta times 1e6 fits in 38 bits signed
    localparam int NUM_W = 38;

    // divider request / answer
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [31:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/tgr_div.sv =====
`timescale 1ns / 1ps
module tgr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tgr_pkg::div_req_t req,
    output tgr_pkg::div_rsp_t rsp
);
    import tgr_pkg::*;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      trial;

    // one restoring step per cycle on unsigned magnitudes
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = 6'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
                rem_next = trial[31:0];
            else
                rem_next = {rem_reg[30:0], quo_reg[NUM_W-1]};
            quo_next = {quo_reg[NUM_W-2:0], ~trial[32]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/touch_gesture_recognizer.sv =====
`timescale 1ns / 1ps
// Touch gesture recognizer: tap, pan and long press from raw touch events.
// Input channel (in_valid/in_stall): op, pos_x, pos_y, stamp. A word is
// taken when in_valid is high and in_stall low.
// Output channel (out_valid/out_stall): one gesture word per handshake,
// up to three per input; last marks the final word of an input.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
// tap_slop, index 1 long_press_time. Write only while the block is idle.
// Down, cancel without a pan and move or up without a touch go from
// decode back to idle; up and a pan-ending cancel pass the emit states
// and an update; a move runs two serial divisions on one shared 38 step
// divider, then the slop test, the emit states and the update.
// One input is handled at a time; in_stall stays high until all its
// words have been taken. An output stall holds the word and the sequencer.
// Reset clears the touch state and loads tap_slop 128, long_press 500000.
module touch_gesture_recognizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [31:0]        stamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         event_kind,
    output logic signed [15:0] at_x,
    output logic signed [15:0] at_y,
    output logic signed [16:0] step_dx,
    output logic signed [16:0] step_dy,
    output logic signed [16:0] total_dx,
    output logic signed [16:0] total_dy,
    output logic signed [30:0] speed_x,
    output logic signed [30:0] speed_y,
    output logic               was_pan,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import tgr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_DIVX, S_WAITX, S_SMX, S_DIVY, S_WAITY, S_SMY,
        S_SLOP, S_EMIT1, S_EMIT2, S_EMIT3, S_UPDATE
    } state_t;

    typedef struct packed {
        logic               valid;
        ev_t                kind;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic               wp;
    } slot_t;

    state_t state_reg;
    logic [15:0] slop_reg;
    logic [31:0] lpt_reg;
    logic touching_reg, panning_reg;
    logic signed [15:0] org_x_reg, org_y_reg, prev_x_reg, prev_y_reg;
    logic [31:0] prev_t_reg, press_t_reg;
    logic signed [30:0] vel_x_reg, vel_y_reg;

    logic [1:0] op_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [31:0] t_reg, dt_reg;
    logic signed [16:0] sdx_reg, sdy_reg, tdx_reg, tdy_reg;
    logic neg_reg;
    logic [NUM_W-1:0] mag_reg;
    logic [33:0] dsq_reg;
    slot_t s1_reg, s2_reg, s3_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    tgr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [31:0] dt_raw;
    logic signed [16:0] delta_cur;
    logic signed [NUM_W-1:0] prod;
    logic [NUM_W-1:0] prod_mag;
    logic signed [NUM_W-1:0] raw_q;
    logic signed [30:0] vel_cur;
    logic signed [39:0] mix;
    logic signed [39:0] fl;
    logic signed [30:0] sat;
    logic signed [17:0] sq_in;
    logic [33:0] sq;
    logic [31:0] slop_sq;
    logic hold_ok;
    logic pan_now;

    assign dt_raw   = t_reg - prev_t_reg;
    assign hold_ok  = (t_reg - press_t_reg) >= lpt_reg;
    assign slop_sq  = slop_reg * slop_reg;
    assign delta_cur = (state_reg == S_DIVX || state_reg == S_SMX) ? sdx_reg : sdy_reg;
    assign prod      = NUM_W'(delta_cur) * NUM_W'(1000000);
    assign prod_mag  = prod[NUM_W-1] ? NUM_W'(-prod) : prod;
    assign raw_q     = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
    assign vel_cur   = (state_reg == S_SMX) ? vel_x_reg : vel_y_reg;
    // 179*old + 77*raw, floored by 256 and clamped
    assign mix = 40'(vel_cur) * 40'sd179 + 40'(raw_q) * 40'sd77;
    assign fl  = mix >>> 8;
    assign sat = (fl > 40'(VEL_MAX)) ? VEL_MAX :
                 (fl < -40'(VEL_MAX)) ? -VEL_MAX : 31'(fl);
    assign sq_in = (state_reg == S_DIVX) ? 18'(tdx_reg) : 18'(tdy_reg);
    assign sq    = 34'($unsigned(36'(sq_in) * 36'(sq_in)));
    // dsq_reg holds dx*dx + dy*dy by the slop test
    assign pan_now = !panning_reg && (35'(dsq_reg) > 35'(slop_sq));

    always_comb
    begin
        dreq.start    = (state_reg == S_DIVX) || (state_reg == S_DIVY);
        dreq.dividend = prod_mag;
        dreq.divisor  = dt_reg;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    slot_t cur;
    always_comb
    begin
        case (state_reg)
            S_EMIT1: cur = s1_reg;
            S_EMIT2: cur = s2_reg;
            default: cur = s3_reg;
        endcase
    end

    logic cur_last;
    always_comb
    begin
        case (state_reg)
            S_EMIT1: cur_last = !s2_reg.valid && !s3_reg.valid;
            S_EMIT2: cur_last = !s3_reg.valid;
            default: cur_last = 1'b1;
        endcase
    end

    logic emitting;
    assign emitting = (state_reg == S_EMIT1 || state_reg == S_EMIT2 ||
                       state_reg == S_EMIT3) && cur.valid;
    assign out_valid  = emitting;
    assign event_kind = cur.kind;
    assign at_x       = cur.ax;
    assign at_y       = cur.ay;
    assign was_pan    = cur.wp;
    assign last       = cur_last;
    assign step_dx    = (cur.kind == EV_PAN_MOVE) ? sdx_reg : 17'sd0;
    assign step_dy    = (cur.kind == EV_PAN_MOVE) ? sdy_reg : 17'sd0;
    assign total_dx   = (cur.kind == EV_PAN_MOVE) ? tdx_reg : 17'sd0;
    assign total_dy   = (cur.kind == EV_PAN_MOVE) ? tdy_reg : 17'sd0;
    assign speed_x    = (cur.kind == EV_PAN_END && op_reg == OP_UP) ? vel_x_reg : 31'sd0;
    assign speed_y    = (cur.kind == EV_PAN_END && op_reg == OP_UP) ? vel_y_reg : 31'sd0;

    function automatic slot_t mk(input logic v, input ev_t k, input logic signed [15:0] ax,
                                 input logic signed [15:0] ay, input logic wp);
        slot_t s;
        s.valid = v;
        s.kind  = k;
        s.ax    = ax;
        s.ay    = ay;
        s.wp    = wp;
        return s;
    endfunction

    // sequencer: state, touch state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            slop_reg     <= TAP_SLOP_RST;
            lpt_reg      <= LONG_PRESS_RST;
            touching_reg <= 1'b0;
            panning_reg  <= 1'b0;
            org_x_reg    <= '0;
            org_y_reg    <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            prev_t_reg   <= '0;
            press_t_reg  <= '0;
            vel_x_reg    <= '0;
            vel_y_reg    <= '0;
            s1_reg       <= '0;
            s2_reg       <= '0;
            s3_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == REG_TAP_SLOP)
                            slop_reg <= cfg_data[15:0];
                        else
                            lpt_reg <= cfg_data;
                    end
                    if (in_valid)
                        state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    s1_reg <= '0;
                    s2_reg <= '0;
                    s3_reg <= '0;
                    case (op_t'(op_reg))
                        OP_DOWN:
                        begin
                            touching_reg <= 1'b1;
                            panning_reg  <= 1'b0;
                            org_x_reg    <= x_reg;
                            org_y_reg    <= y_reg;
                            prev_x_reg   <= x_reg;
                            prev_y_reg   <= y_reg;
                            prev_t_reg   <= t_reg;
                            press_t_reg  <= t_reg;
                            vel_x_reg    <= '0;
                            vel_y_reg    <= '0;
                            state_reg    <= S_IDLE;
                        end
                        OP_MOVE:
                            state_reg <= touching_reg ? S_DIVX : S_IDLE;
                        OP_UP:
                        begin
                            if (touching_reg)
                            begin
                                s1_reg <= mk(!panning_reg && hold_ok, EV_LONG_PRESS,
                                             x_reg, y_reg, 1'b0);
                                s2_reg <= panning_reg ? mk(1'b1, EV_PAN_END, '0, '0, 1'b0)
                                                      : mk(1'b1, EV_TAP, x_reg, y_reg, 1'b0);
                                s3_reg <= mk(1'b1, EV_RELEASE, x_reg, y_reg, panning_reg);
                                state_reg <= S_EMIT1;
                            end
                            else
                            begin
                                touching_reg <= 1'b0;
                                panning_reg  <= 1'b0;
                                state_reg    <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            if (touching_reg && panning_reg)
                            begin
                                s3_reg    <= mk(1'b1, EV_PAN_END, '0, '0, 1'b0);
                                state_reg <= S_EMIT1;
                            end
                            else
                            begin
                                touching_reg <= 1'b0;
                                panning_reg  <= 1'b0;
                                state_reg    <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_DIVX:  state_reg <= S_WAITX;
                S_WAITX: if (drsp.done) state_reg <= S_SMX;
                S_SMX:
                begin
                    vel_x_reg <= sat;
                    state_reg <= S_DIVY;
                end
                S_DIVY:  state_reg <= S_WAITY;
                S_WAITY: if (drsp.done) state_reg <= S_SMY;
                S_SMY:
                begin
                    vel_y_reg <= sat;
                    state_reg <= S_SLOP;
                end
                S_SLOP:
                begin
                    if (pan_now)
                        s1_reg <= mk(1'b1, EV_PAN_START, org_x_reg, org_y_reg, 1'b0);
                    if (pan_now || panning_reg)
                        s3_reg <= mk(1'b1, EV_PAN_MOVE, '0, '0, 1'b0);
                    panning_reg <= panning_reg | pan_now;
                    prev_x_reg  <= x_reg;
                    prev_y_reg  <= y_reg;
                    prev_t_reg  <= t_reg;
                    state_reg   <= S_EMIT1;
                end
                S_EMIT1: if (!emitting || !out_stall) state_reg <= S_EMIT2;
                S_EMIT2: if (!emitting || !out_stall) state_reg <= S_EMIT3;
                S_EMIT3: if (!emitting || !out_stall) state_reg <= S_UPDATE;
                S_UPDATE:
                begin
                    if (op_reg == OP_UP || op_reg == OP_CANCEL)
                    begin
                        touching_reg <= 1'b0;
                        panning_reg  <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // capture the input word and per-move working values
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= op;
            x_reg  <= pos_x;
            y_reg  <= pos_y;
            t_reg  <= stamp;
        end
        if (state_reg == S_DECODE)
        begin
            dt_reg  <= (dt_raw < DT_FLOOR) ? DT_FLOOR : dt_raw;
            sdx_reg <= 17'(x_reg) - 17'(prev_x_reg);
            sdy_reg <= 17'(y_reg) - 17'(prev_y_reg);
            tdx_reg <= 17'(x_reg) - 17'(org_x_reg);
            tdy_reg <= 17'(y_reg) - 17'(org_y_reg);
        end
        if (state_reg == S_DIVX || state_reg == S_DIVY)
            neg_reg <= prod[NUM_W-1];
        if (state_reg == S_DIVX)
            dsq_reg <= sq;
        if (state_reg == S_DIVY)
            dsq_reg <= dsq_reg + sq;
        if ((state_reg == S_WAITX || state_reg == S_WAITY) && drsp.done)
            mag_reg <= drsp.quotient;
    end

endmodule
